// ----- hdl/ntc_pkg.sv -----
// Package for the nearest template classifier: codes, widths, types.
// Used by ntc_dist, nearest_template_classifier and its test.
`default_nettype none
package ntc_pkg;

    localparam int MAX_ENTRIES_DEF = 256;

    localparam int AR_W     = 16;
    localparam int FEAT_W   = 13;
    localparam int LABEL_W  = 8;
    localparam int DIST_W   = 35;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 9;

    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [AR_W-1:0]    ar;
        logic [FEAT_W-1:0]  fill;
        logic [FEAT_W-1:0]  cy;
        logic [LABEL_W-1:0] label;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               vld;
        logic               last;
        logic [LABEL_W-1:0] label;
    } t_tag;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT
    } t_state;

endpackage
`default_nettype wire

// ----- hdl/ntc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ntc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ntc_dist.sv -----
// Three-stage pipeline computing 4*da^2 + 2*df^2 + dc^2 for one template.
// Depends on ntc_pkg.
`default_nettype none
module ntc_dist (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ntc_pkg::t_entry             i_query,
    input  wire ntc_pkg::t_entry             i_entry,
    input  wire ntc_pkg::t_tag               i_tag,
    output ntc_pkg::t_tag                    o_tag,
    output logic [ntc_pkg::DIST_W-1:0]       o_dist
);

    logic [ntc_pkg::AR_W-1:0]     r_da;
    logic [ntc_pkg::FEAT_W-1:0]   r_df;
    logic [ntc_pkg::FEAT_W-1:0]   r_dc;
    logic [2*ntc_pkg::AR_W-1:0]   r_sa;
    logic [2*ntc_pkg::FEAT_W-1:0] r_sf;
    logic [2*ntc_pkg::FEAT_W-1:0] r_sc;
    logic [ntc_pkg::DIST_W-1:0]   r_sum;
    ntc_pkg::t_tag                r_tag1;
    ntc_pkg::t_tag                r_tag2;
    ntc_pkg::t_tag                r_tag3;

    always_ff @(posedge i_clk) begin
        r_da <= (i_query.ar >= i_entry.ar) ? (i_query.ar - i_entry.ar)
                                           : (i_entry.ar - i_query.ar);
        r_df <= (i_query.fill >= i_entry.fill) ? (i_query.fill - i_entry.fill)
                                               : (i_entry.fill - i_query.fill);
        r_dc <= (i_query.cy >= i_entry.cy) ? (i_query.cy - i_entry.cy)
                                           : (i_entry.cy - i_query.cy);
        r_sa <= r_da * r_da;
        r_sf <= r_df * r_df;
        r_sc <= r_dc * r_dc;
        r_sum <= {1'b0, r_sa, 2'b00} + {8'd0, r_sf, 1'b0} + {9'd0, r_sc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
        end
    end

    assign o_tag  = r_tag3;
    assign o_dist = r_sum;

endmodule
`default_nettype wire

// ----- hdl/nearest_template_classifier.sv -----
// Top level of the nearest template classifier: sequencer, template RAM and
// distance pipeline. Depends on ntc_pkg, ntc_ram and ntc_dist.
//
// Usage: drive i_mode and the feature fields with start high; the request is
// taken at a rising edge where start is high and busy is low. Each request
// yields one result on the o_ ports, valid for exactly one cycle with o_done.
// Insert, clear and the unused mode finish at once: o_done rises in the next
// cycle and busy never goes high, so a request may follow every cycle.
// Classify with N stored templates reads the template RAM one entry per
// cycle (its single read port sets the pace) into a three-stage distance
// pipeline; busy stays high until the last distance leaves the pipeline,
// and o_done rises in the same cycle as busy falls. Classify on an
// empty table answers in the next cycle with the empty status.
// Ties keep the lowest entry. Insert on a full table stores nothing and
// answers the full status.
// Reset (i_rst_n low at a clock edge) empties the table and aborts any scan;
// RAM contents are left as they are. The receiver cannot stall: o_done is a
// one-cycle strobe and must be taken when it appears.
`default_nettype none
module nearest_template_classifier #(
    parameter int MAX_ENTRIES = ntc_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ntc_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [ntc_pkg::AR_W-1:0]      i_aspect_ratio,
    input  wire logic [ntc_pkg::FEAT_W-1:0]    i_fill_ratio,
    input  wire logic [ntc_pkg::FEAT_W-1:0]    i_centroid_y,
    input  wire logic [ntc_pkg::LABEL_W-1:0]   i_label_id,
    output logic                               o_done,
    output logic [ntc_pkg::STATUS_W-1:0]       o_status,
    output logic [ntc_pkg::LABEL_W-1:0]        o_best_label,
    output logic [ntc_pkg::DIST_W-1:0]         o_best_distance,
    output logic [ntc_pkg::COUNT_W-1:0]        o_entry_count
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    ntc_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_addr,  n_addr;
    ntc_pkg::t_entry r_query, n_query;
    logic            r_rd_vld, n_rd_vld;
    logic            r_rd_last, n_rd_last;
    logic            r_have,  n_have;
    logic [ntc_pkg::DIST_W-1:0]   r_best_dist,  n_best_dist;
    logic [ntc_pkg::LABEL_W-1:0]  r_best_label, n_best_label;
    logic                         r_done,  n_done;
    logic [ntc_pkg::STATUS_W-1:0] r_status, n_status;
    logic [ntc_pkg::LABEL_W-1:0]  r_out_label, n_out_label;
    logic [ntc_pkg::DIST_W-1:0]   r_out_dist,  n_out_dist;

    logic            w_accept;
    logic            w_full;
    logic            w_scan_last;
    ntc_pkg::t_entry w_in_entry;
    ntc_pkg::t_entry w_rd_entry;
    logic [ntc_pkg::ENTRY_W-1:0] w_rdata;
    logic            w_we;
    logic            w_re;
    ntc_pkg::t_tag   w_tag_in;
    ntc_pkg::t_tag   w_tag_out;
    logic [ntc_pkg::DIST_W-1:0]  w_dist;
    logic            w_take;
    logic [ntc_pkg::DIST_W-1:0]  w_cur_dist;
    logic [ntc_pkg::LABEL_W-1:0] w_cur_label;
    logic [CW+8:0]   w_cnt_ext;

    assign busy        = (r_state != ntc_pkg::S_IDLE);
    assign w_accept    = start && !busy;
    assign w_full      = (r_count == CNT_MAX);
    assign w_scan_last = (CW'(r_addr) == (r_count - CNT_ONE));

    assign w_in_entry.ar    = i_aspect_ratio;
    assign w_in_entry.fill  = i_fill_ratio;
    assign w_in_entry.cy    = i_centroid_y;
    assign w_in_entry.label = i_label_id;

    assign w_rd_entry = w_rdata;

    ntc_ram #(
        .WIDTH (ntc_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_in_entry),
        .i_re    (w_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_tag_in.vld   = r_rd_vld;
    assign w_tag_in.last  = r_rd_last;
    assign w_tag_in.label = w_rd_entry.label;

    ntc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_query (r_query),
        .i_entry (w_rd_entry),
        .i_tag   (w_tag_in),
        .o_tag   (w_tag_out),
        .o_dist  (w_dist)
    );

    assign w_take      = w_tag_out.vld && (!r_have || (w_dist < r_best_dist));
    assign w_cur_dist  = w_take ? w_dist : r_best_dist;
    assign w_cur_label = w_take ? w_tag_out.label : r_best_label;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ntc_pkg::S_IDLE: begin
                if (w_accept && (i_mode == ntc_pkg::MODE_CLASSIFY) && (r_count != '0)) begin
                    n_state = ntc_pkg::S_SCAN;
                end
            end
            ntc_pkg::S_SCAN: begin
                if (w_scan_last) begin
                    n_state = ntc_pkg::S_WAIT;
                end
            end
            ntc_pkg::S_WAIT: begin
                if (w_tag_out.vld && w_tag_out.last) begin
                    n_state = ntc_pkg::S_IDLE;
                end
            end
            default: n_state = ntc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_addr       = r_addr;
        n_query      = r_query;
        n_rd_vld     = 1'b0;
        n_rd_last    = 1'b0;
        n_have       = r_have || w_tag_out.vld;
        n_best_dist  = w_cur_dist;
        n_best_label = w_cur_label;
        n_done       = 1'b0;
        n_status     = r_status;
        n_out_label  = r_out_label;
        n_out_dist   = r_out_dist;
        w_we         = 1'b0;
        w_re         = 1'b0;
        unique case (r_state)
            ntc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_status    = ntc_pkg::STAT_OK;
                    n_out_label = '0;
                    n_out_dist  = '0;
                    n_done      = 1'b1;
                    unique case (i_mode)
                        ntc_pkg::MODE_INSERT: begin
                            if (w_full) begin
                                n_status = ntc_pkg::STAT_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CNT_ONE;
                            end
                        end
                        ntc_pkg::MODE_CLASSIFY: begin
                            if (r_count == '0) begin
                                n_status = ntc_pkg::STAT_EMPTY;
                            end else begin
                                n_done  = 1'b0;
                                n_query = w_in_entry;
                                n_have  = 1'b0;
                                n_addr  = '0;
                            end
                        end
                        ntc_pkg::MODE_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            ntc_pkg::S_SCAN: begin
                w_re      = 1'b1;
                n_rd_vld  = 1'b1;
                n_rd_last = w_scan_last;
                n_addr    = r_addr + AW'(1);
            end
            ntc_pkg::S_WAIT: begin
                if (w_tag_out.vld && w_tag_out.last) begin
                    n_done      = 1'b1;
                    n_status    = ntc_pkg::STAT_OK;
                    n_out_label = w_cur_label;
                    n_out_dist  = w_cur_dist;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ntc_pkg::S_IDLE;
            r_count   <= '0;
            r_addr    <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_have    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_addr    <= n_addr;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
            r_have    <= n_have;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query      <= n_query;
        r_best_dist  <= n_best_dist;
        r_best_label <= n_best_label;
        r_status     <= n_status;
        r_out_label  <= n_out_label;
        r_out_dist   <= n_out_dist;
    end

    assign w_cnt_ext       = {9'd0, r_count};
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_best_label    = r_out_label;
    assign o_best_distance = r_out_dist;
    assign o_entry_count   = w_cnt_ext[8:0];

endmodule
`default_nettype wire

// ----- dv/nearest_template_classifier_test.sv -----
// Self-checking test of nearest_template_classifier: a directed table, a fill to full
// table, then random insert, classify, clear and unused-mode traffic checked against a
// built-in model. Depends on ntc_pkg and the classifier RTL.
module nearest_template_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ntc_pkg::*;

    localparam int TABLE_DEPTH     = MAX_ENTRIES_DEF;
    localparam int RANDOM_REQUESTS = 1572;
    localparam int CYCLE_LIMIT     = 2_500_000;
    localparam int DRAIN_CYCLES    = 280;
    localparam int DIRECTED_ROWS   = 20;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [AR_W-1:0]   AR_TOP      = '1;
    localparam logic [FEAT_W-1:0] FEAT_TOP    = '1;
    localparam logic [FEAT_W-1:0] FEAT_ONE    = 13'd4096;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [AR_W-1:0]    ar;
        logic [FEAT_W-1:0]  fill;
        logic [FEAT_W-1:0]  cy;
        logic [LABEL_W-1:0] label;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LABEL_W-1:0]  label;
        logic [DIST_W-1:0]   distance;
        logic [COUNT_W-1:0]  count;
    } answer_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        answer_t  want;
    } directed_row_t;

    localparam answer_t MODEL_ANSWER = '0;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{MODE_CLASSIFY, 16'h0000, 13'h0000, 13'h0000, 8'h00}, 1'b1,
          '{STAT_EMPTY, 8'h00, 35'd0, 9'd0}},
        '{'{MODE_UNUSED, AR_TOP, FEAT_TOP, FEAT_TOP, 8'hFF}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd0}},
        '{'{MODE_CLEAR, 16'h0000, 13'h0000, 13'h0000, 8'h00}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd0}},
        '{'{MODE_INSERT, 16'h0000, 13'h0000, 13'h0000, 8'h00}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd1}},
        '{'{MODE_INSERT, AR_TOP, FEAT_TOP, FEAT_TOP, 8'hFF}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd2}},
        '{'{MODE_CLASSIFY, 16'h0000, 13'h0000, 13'h0000, 8'h00}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd2}},
        '{'{MODE_CLASSIFY, AR_TOP, FEAT_TOP, FEAT_TOP, 8'h00}, 1'b1,
          '{STAT_OK, 8'hFF, 35'd0, 9'd2}},
        '{'{MODE_INSERT, 16'h0000, 13'h0000, 13'h0000, 8'h5A}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd3}},
        '{'{MODE_CLASSIFY, 16'h0001, 13'h0000, 13'h0000, 8'h00}, 1'b1,
          '{STAT_OK, 8'h00, 35'd4, 9'd3}},
        '{'{MODE_CLASSIFY, 16'h1000, FEAT_ONE, FEAT_ONE, 8'h00}, 1'b0, MODEL_ANSWER},
        '{'{MODE_UNUSED, 16'h0000, 13'h0000, 13'h0000, 8'h00}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd3}},
        '{'{MODE_CLEAR, AR_TOP, FEAT_TOP, FEAT_TOP, 8'hFF}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd0}},
        '{'{MODE_CLASSIFY, AR_TOP, FEAT_TOP, FEAT_TOP, 8'hFF}, 1'b1,
          '{STAT_EMPTY, 8'h00, 35'd0, 9'd0}},
        '{'{MODE_INSERT, 16'h0000, 13'h0000, 13'h0000, 8'h3C}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd1}},
        '{'{MODE_CLASSIFY, AR_TOP, FEAT_TOP, FEAT_TOP, 8'h00}, 1'b1,
          '{STAT_OK, 8'h3C, 35'd17380622343, 9'd1}},
        '{'{MODE_INSERT, 16'h1000, FEAT_ONE, 13'd2048, 8'h11}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd2}},
        '{'{MODE_INSERT, 16'h2000, 13'd0, FEAT_ONE, 8'h22}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd3}},
        '{'{MODE_CLASSIFY, 16'h1800, 13'd2048, 13'd3072, 8'h00}, 1'b0, MODEL_ANSWER},
        '{'{MODE_CLASSIFY, 16'h0800, FEAT_ONE, 13'd1024, 8'h00}, 1'b0, MODEL_ANSWER},
        '{'{MODE_CLEAR, 16'h0000, 13'h0000, 13'h0000, 8'h00}, 1'b1,
          '{STAT_OK, 8'h00, 35'd0, 9'd0}}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [MODE_W-1:0]   i_mode;
    logic [AR_W-1:0]     i_aspect_ratio;
    logic [FEAT_W-1:0]   i_fill_ratio;
    logic [FEAT_W-1:0]   i_centroid_y;
    logic [LABEL_W-1:0]  i_label_id;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [LABEL_W-1:0]  o_best_label;
    logic [DIST_W-1:0]   o_best_distance;
    logic [COUNT_W-1:0]  o_entry_count;

    t_entry  shadow_table [TABLE_DEPTH];
    int      shadow_count = 0;
    answer_t answer_q [$];

    int cycle_count = 0;
    int n_requests = 0;
    int n_insert = 0;
    int n_full = 0;
    int n_classify = 0;
    int n_empty = 0;
    int n_clear = 0;
    int n_unused = 0;
    int n_checked = 0;
    int n_mismatch = 0;

    nearest_template_classifier uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_aspect_ratio  (i_aspect_ratio),
        .i_fill_ratio    (i_fill_ratio),
        .i_centroid_y    (i_centroid_y),
        .i_label_id      (i_label_id),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_best_label    (o_best_label),
        .o_best_distance (o_best_distance),
        .o_entry_count   (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, answer_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint unsigned sq_gap(longint unsigned a, longint unsigned b);
        longint unsigned d;
        d = (a >= b) ? a - b : b - a;
        return d * d;
    endfunction

    // Apply one accepted request to the shadow table and return its answer.
    function automatic answer_t serve_request(request_t r);
        answer_t         a;
        longint unsigned d;
        longint unsigned best;
        int              i;
        a = '0;
        best = 0;
        case (r.mode)
            MODE_INSERT: begin
                if (shadow_count < TABLE_DEPTH) begin
                    shadow_table[shadow_count] = '{ar: r.ar, fill: r.fill, cy: r.cy,
                                                   label: r.label};
                    shadow_count++;
                    n_insert++;
                end else begin
                    a.status = STAT_FULL;
                    n_full++;
                end
            end
            MODE_CLASSIFY: begin
                n_classify++;
                if (shadow_count == 0) begin
                    a.status = STAT_EMPTY;
                    n_empty++;
                end else begin
                    for (i = 0; i < shadow_count; i++) begin
                        d = 4 * sq_gap(r.ar, shadow_table[i].ar)
                          + 2 * sq_gap(r.fill, shadow_table[i].fill)
                          + sq_gap(r.cy, shadow_table[i].cy);
                        if (i == 0 || d < best) begin
                            best = d;
                            a.label = shadow_table[i].label;
                        end
                    end
                    a.distance = best[DIST_W-1:0];
                end
            end
            MODE_CLEAR: begin
                shadow_count = 0;
                n_clear++;
            end
            default: n_unused++;
        endcase
        a.count = shadow_count[COUNT_W-1:0];
        return a;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        int       k;
        pick = $urandom_range(99);
        r.mode = (pick < 45) ? MODE_INSERT :
                 (pick < 90) ? MODE_CLASSIFY :
                 (pick < 96) ? MODE_CLEAR : MODE_UNUSED;
        pick = $urandom_range(99);
        if (pick < 40 && shadow_count > 0) begin
            // land on or next to a stored template to force ties and near misses
            k = $urandom_range(shadow_count - 1);
            r.ar = shadow_table[k].ar;
            r.fill = shadow_table[k].fill;
            r.cy = shadow_table[k].cy;
            if (pick % 2 == 1) begin
                r.ar ^= AR_W'($urandom_range(31));
                r.fill ^= FEAT_W'($urandom_range(31));
                r.cy ^= FEAT_W'($urandom_range(31));
            end
        end else if (pick < 55) begin
            r.ar = $urandom_range(1) ? AR_TOP : '0;
            r.fill = ($urandom_range(2) == 0) ? FEAT_TOP : $urandom_range(1) ? FEAT_ONE : '0;
            r.cy = ($urandom_range(2) == 0) ? FEAT_TOP : $urandom_range(1) ? FEAT_ONE : '0;
        end else begin
            r.ar = AR_W'($urandom_range(16'hFFFF));
            r.fill = FEAT_W'($urandom_range(1) ? $urandom_range(4096) : $urandom_range(8191));
            r.cy = FEAT_W'($urandom_range(1) ? $urandom_range(4096) : $urandom_range(8191));
        end
        r.label = LABEL_W'($urandom_range(255));
        return r;
    endfunction

    // Hold start high until the request is taken, then log its answer.
    task automatic send_request(input request_t r, input int idle_pct, input logic typed,
                                input answer_t want);
        answer_t predicted;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= r.mode;
        i_aspect_ratio <= r.ar;
        i_fill_ratio <= r.fill;
        i_centroid_y <= r.cy;
        i_label_id <= r.label;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = serve_request(r);
        answer_q.push_back(typed ? want : predicted);
        n_requests++;
    endtask

    task automatic fill_table(input int idle_pct);
        request_t r;
        while (shadow_count < TABLE_DEPTH) begin
            r = random_request();
            r.mode = MODE_INSERT;
            send_request(r, idle_pct, 1'b0, MODEL_ANSWER);
        end
    endtask

    task automatic drain_answers();
        start <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int requests, input int idle_pct);
        int sent;
        sent = 0;
        while (sent < requests) begin
            if ($urandom_range(999) < 3) begin
                sent += TABLE_DEPTH - shadow_count;
                fill_table(idle_pct);
            end else begin
                send_request(random_request(), idle_pct, 1'b0, MODEL_ANSWER);
                sent++;
            end
        end
    endtask

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            n_mismatch++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        answer_t want;
        if (i_rst_n && o_done) begin
            n_checked++;
            if (answer_q.size() == 0) begin
                n_mismatch++;
                $error("result with no request pending: status %0d label %0d",
                       o_status, o_best_label);
            end else begin
                want = answer_q.pop_front();
                check_field("status", want.status, o_status);
                check_field("best_label", want.label, o_best_label);
                check_field("best_distance", want.distance, o_best_distance);
                check_field("entry_count", want.count, o_entry_count);
            end
        end
    end

    initial begin
        int       n;
        int       idle_levels [3];
        request_t extra;
        answer_t  full_answer;
        idle_levels = '{35, 87, 0};
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_mode <= MODE_INSERT;
        i_aspect_ratio <= '0;
        i_fill_ratio <= '0;
        i_centroid_y <= '0;
        i_label_id <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            send_request(DIRECTED[n].req, 0, DIRECTED[n].typed, DIRECTED[n].want);
        end

        fill_table(0);
        extra = '{MODE_INSERT, AR_TOP, FEAT_TOP, FEAT_TOP, 8'hA5};
        full_answer = '{STAT_FULL, 8'h00, 35'd0, 9'd256};
        send_request(extra, 0, 1'b1, full_answer);
        extra = random_request();
        extra.mode = MODE_CLASSIFY;
        send_request(extra, 0, 1'b0, MODEL_ANSWER);
        extra.mode = MODE_UNUSED;
        send_request(extra, 0, 1'b0, MODEL_ANSWER);
        extra.mode = MODE_CLEAR;
        send_request(extra, 0, 1'b0, MODEL_ANSWER);

        for (n = 0; n < 3; n++) begin
            random_traffic(RANDOM_REQUESTS / 3, idle_levels[n]);
            drain_answers();
        end

        drain_answers();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (answer_q.size() != 0) begin
            n_mismatch++;
            $error("%0d expected results never arrived", answer_q.size());
        end
        $display("Covered %0d requests: %0d stored, %0d refused on a full table, %0d classify",
                 n_requests, n_insert, n_full, n_classify);
        $display("  (%0d on empty table), %0d clear, %0d unused mode; %0d results checked",
                 n_empty, n_clear, n_unused, n_checked);
        if (n_mismatch == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
